// ===== src/ccc_pkg.sv =====
// Package for the choice combination counter.
// Holds widths, operation codes and the structs shared with the step unit.
// No dependencies.
package ccc_pkg;

	// Largest target count; larger requests are clamped to this.
	localparam int MAX_TARGETS = 31;

	// Width of the target and pick count fields.
	localparam int N_W = 5;
	// Divisor j+1 reaches at most MAX_TARGETS; one bit wider than a count for the shifted remainder.
	localparam int DIV_W = N_W + 1;
	// C(31,j) peaks at C(31,15) = 300540195, below 2^30.
	localparam int ACC_W = 30;
	// Product of a coefficient and a count.
	localparam int PROD_W = ACC_W + N_W;
	// Bit counter for the serial divide.
	localparam int CNT_W = $clog2(PROD_W);
	// Running sum reaches 2^31 for the full row of 31.
	localparam int TOT_W = 32;
	// Output count field.
	localparam int CNT_OUT_W = 31;

	typedef enum logic [1:0] {
		OP_SINGLE = 2'd0,
		OP_EXACT  = 2'd1,
		OP_UPTO   = 2'd2,
		OP_UNUSED = 2'd3
	} ccc_op_t;

	// Request to the multiply-then-divide unit: quot = acc * mult / divisor.
	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] acc;
		logic [N_W-1:0]   mult;
		logic [DIV_W-1:0] divisor;
	} ccc_step_req_t;

	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] quot;
	} ccc_step_rsp_t;

endpackage

// ===== src/ccc_req_if.sv =====
// Request channel of the choice combination counter.
// Depends on ccc_pkg for the field widths.
interface ccc_req_if
	import ccc_pkg::*;
;
	logic           valid;
	logic           ready;
	logic [1:0]     operation;
	logic [N_W-1:0] target_count;
	logic [N_W-1:0] pick_count;

	modport source (output valid, operation, target_count, pick_count, input ready);
	modport sink (input valid, operation, target_count, pick_count, output ready);
endinterface

// ===== src/ccc_rsp_if.sv =====
// Result channel of the choice combination counter.
// Depends on ccc_pkg for the field widths.
interface ccc_rsp_if
	import ccc_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CNT_OUT_W-1:0] option_count;
	logic                 saturated;

	modport source (output valid, option_count, saturated, input ready);
	modport sink (input valid, option_count, saturated, output ready);
endinterface

// ===== src/ccc_muldiv.sv =====
// Shared step unit: one multiply, then an exact restoring divide, one bit per cycle.
// Depends on ccc_pkg.
module ccc_muldiv
	import ccc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  ccc_step_req_t req,
	output ccc_step_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] dvd_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  div_q;

	logic [DIV_W-1:0]  trial;
	logic              qbit;
	logic [DIV_W-1:0]  rem_next;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial    = {rem_q[DIV_W-2:0], dvd_q[PROD_W-1]};
		qbit     = (trial >= div_q);
		rem_next = qbit ? (trial - div_q) : trial;
	end

	// Control: busy through the serial divide after the multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PROD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load the product, then shift quotient bits in as dividend bits leave
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= PROD_W'(req.acc) * PROD_W'(req.mult);
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PROD_W-2:0], qbit};
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q[ACC_W-1:0];

endmodule

// ===== src/choice_combination_counter.sv =====
// Choice combination counter: single pick, exact C(n,k), or partial row sum up to k.
// Single and unused operations go straight to the result; the unused code gives zero. Binomial
// modes take s steps, s = min(k,n-k) (exact) or min(k,n) (up to).
// Each step goes through the shared multiply / serial divide unit.
// One item at a time; a new request is taken while the previous result waits.
// Reset clears the sequencer, the result valid and the step unit's control; no other state.
module choice_combination_counter
	import ccc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	ccc_req_if.sink         req,
	ccc_rsp_if.source       rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_WAIT,
		ST_FIN
	} state_t;

	localparam logic [N_W-1:0] MAX_N = N_W'(MAX_TARGETS);

	state_t               state_q;
	logic                 sum_q;
	logic [N_W-1:0]       n_q;
	logic [N_W-1:0]       j_q;
	logic [N_W-1:0]       limit_q;
	logic [ACC_W-1:0]     acc_q;
	logic [TOT_W-1:0]     total_q;
	logic                 rsp_valid_q;
	logic [CNT_OUT_W-1:0] count_q;
	logic                 sat_q;

	logic                 req_xfer;
	logic [N_W-1:0]       n_in;
	logic [N_W-1:0]       k_in;
	logic [N_W-1:0]       n_minus_k;
	logic                 rsp_free;
	logic                 sat_now;
	ccc_step_req_t        step_req;
	ccc_step_rsp_t        step_rsp;

	// Clamp the target count and form the symmetric pick count
	always_comb begin
		n_in      = (req.target_count > MAX_N) ? MAX_N : req.target_count;
		k_in      = req.pick_count;
		n_minus_k = n_in - k_in;
	end

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign sat_now   = (total_q > TOT_W'({CNT_OUT_W{1'b1}}));

	// Next coefficient: C(n,j+1) = C(n,j) * (n-j) / (j+1)
	always_comb begin
		step_req.start   = (state_q == ST_STEP);
		step_req.acc     = acc_q;
		step_req.mult    = n_q - j_q;
		step_req.divisor = DIV_W'(j_q) + 1'b1;
	end

	ccc_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (step_req),
		.rsp    (step_rsp)
	);

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			// Load a finished result, or drop the one just transferred
			if (state_q == ST_FIN && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						unique case (ccc_op_t'(req.operation))
							OP_SINGLE: state_q <= ST_FIN;
							OP_EXACT: begin
								if (n_in <= k_in) begin
									state_q <= ST_FIN;
								end else if (((k_in < n_minus_k) ? k_in : n_minus_k) == '0) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_STEP;
								end
							end
							OP_UPTO: begin
								if (((k_in < n_in) ? k_in : n_in) == '0) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_STEP;
								end
							end
							OP_UNUSED: state_q <= ST_FIN;
						endcase
					end
				end
				ST_STEP: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (step_rsp.done) begin
						state_q <= (N_W'(j_q + 1'b1) == limit_q) ? ST_FIN : ST_STEP;
					end
				end
				ST_FIN: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Working registers and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					n_q   <= n_in;
					j_q   <= '0;
					acc_q <= ACC_W'(1);
					sum_q <= 1'b0;
					unique case (ccc_op_t'(req.operation))
						OP_SINGLE: begin
							total_q <= TOT_W'(n_in);
							limit_q <= '0;
						end
						OP_EXACT: begin
							total_q <= TOT_W'(1);
							limit_q <= (k_in < n_minus_k) ? k_in : n_minus_k;
						end
						OP_UPTO: begin
							total_q <= TOT_W'(1);
							sum_q   <= 1'b1;
							limit_q <= (k_in < n_in) ? k_in : n_in;
						end
						OP_UNUSED: begin
							total_q <= '0;
							limit_q <= '0;
						end
					endcase
				end
			end
			ST_STEP: begin
			end
			ST_WAIT: begin
				if (step_rsp.done) begin
					acc_q   <= step_rsp.quot;
					j_q     <= N_W'(j_q + 1'b1);
					total_q <= sum_q ? (total_q + TOT_W'(step_rsp.quot))
					                 : TOT_W'(step_rsp.quot);
				end
			end
			ST_FIN: begin
				if (rsp_free) begin
					count_q <= sat_now ? {CNT_OUT_W{1'b1}} : total_q[CNT_OUT_W-1:0];
					sat_q   <= sat_now;
				end
			end
		endcase
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.option_count = count_q;
	assign rsp.saturated    = sat_q;

endmodule

// ===== verif/tb_top.sv =====
// Testbench for choice_combination_counter: directed corner requests, then random ones,
// each result checked against an in-bench count predictor held in a small scoreboard.
// Depends on ccc_pkg, ccc_req_if, ccc_rsp_if and the counter RTL.
module tb_top;
	import ccc_pkg::*;

	localparam longint unsigned COUNT_CEIL = 64'd2147483647;
	localparam int RANDOM_REQUESTS = 400;
	localparam int DRAIN_CYCLES = 1200;

	// Expected option counts, oldest first, and the predictor that fills them.
	class option_count_board;
		typedef struct {
			logic [CNT_OUT_W-1:0] count;
			logic                 sat;
		} option_t;

		option_t pending[$];
		int      errors;

		function new();
			errors = 0;
		endfunction

		// C(n,k) by multiply-then-divide over the smaller side
		function longint unsigned binom(longint unsigned n, longint unsigned k);
			longint unsigned acc;
			longint unsigned i;
			acc = 1;
			if (k > n) return 0;
			if (k > n - k) k = n - k;
			for (i = 0; i < k; i++) acc = acc * (n - i) / (i + 1);
			return acc;
		endfunction

		function void note_request(ccc_op_t op, logic [N_W-1:0] n_in, logic [N_W-1:0] k_in);
			longint unsigned n;
			longint unsigned k;
			longint unsigned total;
			longint unsigned j;
			option_t want;
			n = n_in;
			k = k_in;
			if (n > MAX_TARGETS) n = MAX_TARGETS;
			case (op)
				OP_SINGLE: total = n;
				OP_EXACT:  total = (n <= k) ? 1 : binom(n, k);
				OP_UPTO: begin
					// terms past n are zero, so stop at the smaller bound
					total = 0;
					for (j = 0; j <= n && j <= k; j++) total += binom(n, j);
				end
				default:   total = 0;
			endcase
			want.sat = (total > COUNT_CEIL);
			if (want.sat) total = COUNT_CEIL;
			want.count = total[CNT_OUT_W-1:0];
			pending.push_back(want);
		endfunction

		function void check_result(logic [CNT_OUT_W-1:0] count, logic sat);
			option_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, option_count %0d saturated %0b",
					$time, count, sat);
				return;
			end
			want = pending.pop_front();
			if (count !== want.count) begin
				errors++;
				$display("%0t: option_count expected %0d got %0d", $time, want.count, count);
			end
			if (sat !== want.sat) begin
				errors++;
				$display("%0t: saturated expected %0b got %0b", $time, want.sat, sat);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   sent;
	int   got;

	option_count_board board = new();

	ccc_req_if req_ch();
	ccc_rsp_if rsp_ch();

	choice_combination_counter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// Hard stop in case the block hangs
	initial begin
		#20000000;
		$display("choice_combination_counter verification failed");
		$finish;
	end

	// Result side: stall at random, except over a calm stretch
	always @(negedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= (got >= 150 && got < 250) || ($urandom_range(0, 99) >= 25);
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			board.check_result(rsp_ch.option_count, rsp_ch.saturated);
			got++;
		end
	end

	// Drive one request; called and returns at a falling edge
	task automatic send_request(ccc_op_t op, logic [N_W-1:0] n, logic [N_W-1:0] k);
		while (!(sent >= 150 && sent < 250) && $urandom_range(0, 99) < 25) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.operation    <= op;
		req_ch.target_count <= n;
		req_ch.pick_count   <= k;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		board.note_request(op, n, k);
		sent++;
		@(negedge clk);
	endtask

	initial begin
		ccc_op_t         op;
		logic [N_W-1:0]  n;
		logic [N_W-1:0]  k;
		int              sel;
		clk                 = 1'b0;
		arst_n              = 1'b0;
		sent                = 0;
		got                 = 0;
		req_ch.valid        = 1'b0;
		req_ch.operation    = OP_SINGLE;
		req_ch.target_count = '0;
		req_ch.pick_count   = '0;
		rsp_ch.ready        = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Field extremes and the unused code
		send_request(OP_SINGLE, 5'd0, 5'd0);
		send_request(OP_SINGLE, 5'd31, 5'd31);
		send_request(OP_UNUSED, 5'd31, 5'd31);
		send_request(OP_UNUSED, 5'd0, 5'd0);
		// Exact mode: no targets, pick above n, peak of the row, symmetric sides
		send_request(OP_EXACT, 5'd0, 5'd0);
		send_request(OP_EXACT, 5'd0, 5'd31);
		send_request(OP_EXACT, 5'd5, 5'd31);
		send_request(OP_EXACT, 5'd31, 5'd31);
		send_request(OP_EXACT, 5'd31, 5'd0);
		send_request(OP_EXACT, 5'd31, 5'd1);
		send_request(OP_EXACT, 5'd31, 5'd15);
		send_request(OP_EXACT, 5'd31, 5'd16);
		send_request(OP_EXACT, 5'd31, 5'd30);
		send_request(OP_EXACT, 5'd10, 5'd3);
		// Up-to mode: full row saturates, one short of it lands on the ceiling
		send_request(OP_UPTO, 5'd31, 5'd31);
		send_request(OP_UPTO, 5'd31, 5'd30);
		send_request(OP_UPTO, 5'd0, 5'd0);
		send_request(OP_UPTO, 5'd0, 5'd31);
		send_request(OP_UPTO, 5'd20, 5'd31);
		send_request(OP_UPTO, 5'd31, 5'd0);
		send_request(OP_UPTO, 5'd31, 5'd15);
		send_request(OP_UPTO, 5'd12, 5'd5);

		// Random requests, weighted toward the binomial modes and small n
		repeat (RANDOM_REQUESTS) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				op = OP_SINGLE;
			else if (sel == 1)
				op = OP_UNUSED;
			else if (sel < 6)
				op = OP_EXACT;
			else
				op = OP_UPTO;
			n = ($urandom_range(0, 3) == 0) ? N_W'($urandom_range(0, 31))
				: N_W'($urandom_range(0, 15));
			k = N_W'($urandom_range(0, 31));
			send_request(op, n, k);
		end
		req_ch.valid <= 1'b0;

		// Drain outstanding results, then watch for stray ones
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("choice_combination_counter verification clean");
		else
			$display("choice_combination_counter verification failed");
		$finish;
	end
endmodule

// ===== choice_combination_counter.f =====
src/ccc_pkg.sv
src/ccc_req_if.sv
src/ccc_rsp_if.sv
src/ccc_muldiv.sv
src/choice_combination_counter.sv
verif/tb_top.sv
